// ----- rtl/rwc_pkg.sv -----
// ---------------------------------------------------------------------------
// rwc_pkg
// Shared types and codes for the replay window check block: status codes,
// request modes, register indexes and the configuration struct.
// ---------------------------------------------------------------------------
package rwc_pkg;

   localparam int SEQ_W    = 32;
   localparam int WIN_W    = 5;
   localparam int STATUS_W = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_WRAPPED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REPLAY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OLD     = 2'd3;

   // request modes
   localparam logic MODE_CHECK    = 1'b0;
   localparam logic MODE_ROLLBACK = 1'b1;

   // register index, taken from paddr bit 2
   localparam logic REG_WINDOW_SIZE    = 1'b0;
   localparam logic REG_SEQUENCE_LIMIT = 1'b1;

   localparam logic [WIN_W-1:0] WINDOW_SIZE_RESET    = 5'd31;
   localparam logic [SEQ_W-1:0] SEQUENCE_LIMIT_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [WIN_W-1:0] window_size;
      logic [SEQ_W-1:0] sequence_limit;
   } cfg_type;

endpackage

// ----- rtl/rwc_csr.sv -----
// ---------------------------------------------------------------------------
// rwc_csr
// APB-style register file holding the window size and the sequence limit.
// ---------------------------------------------------------------------------
module rwc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rwc_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [rwc_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [rwc_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready,
   output rwc_pkg::cfg_type                cfg
);

   rwc_pkg::cfg_type cfg_ff;
   rwc_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            rwc_pkg::REG_WINDOW_SIZE:
               cfg_in.window_size = csr_pwdata[rwc_pkg::WIN_W-1:0];
            rwc_pkg::REG_SEQUENCE_LIMIT:
               cfg_in.sequence_limit = csr_pwdata[rwc_pkg::SEQ_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         rwc_pkg::REG_WINDOW_SIZE:
            csr_prdata = {{(rwc_pkg::CSR_DW-rwc_pkg::WIN_W){1'b0}}, cfg_ff.window_size};
         rwc_pkg::REG_SEQUENCE_LIMIT:
            csr_prdata = cfg_ff.sequence_limit;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_size    <= rwc_pkg::WINDOW_SIZE_RESET;
         cfg_ff.sequence_limit <= rwc_pkg::SEQUENCE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/rwc_window.sv -----
// ---------------------------------------------------------------------------
// rwc_window
// Window state and the combinational classification of one request.
// State is committed when the request moves to the result register.
// ---------------------------------------------------------------------------
module rwc_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              commit,
   input  logic                              mode,
   input  logic [rwc_pkg::SEQ_W-1:0]         seq,
   input  rwc_pkg::cfg_type                  cfg,
   output logic [rwc_pkg::STATUS_W-1:0]      status
);

   logic [rwc_pkg::SEQ_W-1:0] last_ff, last_in;
   logic [rwc_pkg::SEQ_W-1:0] highest_ff, highest_in;
   logic [rwc_pkg::SEQ_W-1:0] bits_ff, bits_in;
   logic                      first_ff, first_in;
   logic [rwc_pkg::SEQ_W-1:0] saved_last_ff, saved_last_in;
   logic [rwc_pkg::SEQ_W-1:0] saved_bits_ff, saved_bits_in;

   logic                      wrapped;
   logic                      newer;
   logic                      equal;
   logic                      too_old;
   logic [rwc_pkg::SEQ_W-1:0] fwd_dist;
   logic [rwc_pkg::SEQ_W-1:0] back_dist;
   logic [rwc_pkg::SEQ_W-1:0] shifted;
   logic [rwc_pkg::SEQ_W-1:0] mask;
   logic [rwc_pkg::SEQ_W:0]   reach;

   assign wrapped   = last_ff >= cfg.sequence_limit;
   assign newer     = seq > highest_ff;
   assign equal     = seq == highest_ff;
   assign fwd_dist  = seq - highest_ff;
   assign back_dist = highest_ff - seq;
   // shift of 32 or more empties the window
   assign shifted   = (fwd_dist[rwc_pkg::SEQ_W-1:rwc_pkg::WIN_W] != '0) ? '0
                      : (bits_ff << fwd_dist[rwc_pkg::WIN_W-1:0]);
   assign mask      = {{(rwc_pkg::SEQ_W-1){1'b0}}, 1'b1} << back_dist[rwc_pkg::WIN_W-1:0];
   assign reach     = {1'b0, seq}
                      + {{(rwc_pkg::SEQ_W+1-rwc_pkg::WIN_W){1'b0}}, cfg.window_size};
   assign too_old   = reach < {1'b0, highest_ff};

   always_comb begin
      last_in       = last_ff;
      highest_in    = highest_ff;
      bits_in       = bits_ff;
      first_in      = first_ff;
      saved_last_in = saved_last_ff;
      saved_bits_in = saved_bits_ff;
      status        = rwc_pkg::STATUS_OK;
      if (mode == rwc_pkg::MODE_ROLLBACK) begin
         // zero in a saved copy means nothing to restore
         if (saved_bits_ff != '0) begin
            bits_in       = saved_bits_ff;
            saved_bits_in = '0;
         end
         if (saved_last_ff != '0) begin
            last_in       = saved_last_ff;
            saved_last_in = '0;
         end
      end else if (wrapped) begin
         status = rwc_pkg::STATUS_WRAPPED;
      end else begin
         saved_last_in = last_ff;
         saved_bits_in = bits_ff;
         if (newer) begin
            bits_in    = shifted;
            highest_in = seq;
            last_in    = seq;
         end else if (equal) begin
            if (!first_ff) begin
               status = rwc_pkg::STATUS_REPLAY;
            end else begin
               first_in = 1'b0;
               last_in  = seq;
            end
         end else if (too_old) begin
            status = rwc_pkg::STATUS_OLD;
         end else if ((bits_ff & mask) != '0) begin
            status = rwc_pkg::STATUS_REPLAY;
         end else begin
            bits_in = bits_ff | mask;
            last_in = seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff       <= '0;
         highest_ff    <= '0;
         bits_ff       <= '0;
         first_ff      <= 1'b1;
         saved_last_ff <= '0;
         saved_bits_ff <= '0;
      end else if (commit) begin
         last_ff       <= last_in;
         highest_ff    <= highest_in;
         bits_ff       <= bits_in;
         first_ff      <= first_in;
         saved_last_ff <= saved_last_in;
         saved_bits_ff <= saved_bits_in;
      end
   end

endmodule

// ----- rtl/replay_window_check.sv -----
// ---------------------------------------------------------------------------
// replay_window_check
// Sliding-window anti-replay check on 32-bit sequence numbers with a
// one-step roll-back of the last check.
//
// Requests arrive on the req_ channel (valid/ready): req_mode selects a check
// of req_sequence_req or a roll-back. Each request yields exactly one status
// on the rsp_ channel (valid/ready): accepted, wrapped, replay or old.
// A request is held in an input register; the window state is read, updated
// and the status loaded into the result register in one step. One request
// per cycle is sustained while the receiver takes results; the only path is
// the compare/shift logic between the two registers. When the receiver
// stalls, the result register holds its status and one more request waits in
// the input register, after which req_ready drops. Synchronous reset empties
// both registers, clears the window state (first-number flag set) and loads
// the register defaults: window size 31, sequence limit all ones. Registers
// are written over the csr_ APB port at byte addresses 0 and 4; the user must
// write them only while no request is in flight; the block never checks it.
// ---------------------------------------------------------------------------
module replay_window_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [rwc_pkg::SEQ_W-1:0]         req_sequence_req,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rwc_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rwc_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [rwc_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [rwc_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);

   rwc_pkg::cfg_type                cfg;
   logic                            in_valid_ff, in_valid_in;
   logic                            in_mode_ff;
   logic [rwc_pkg::SEQ_W-1:0]       in_seq_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [rwc_pkg::STATUS_W-1:0]    out_status_ff;
   logic [rwc_pkg::STATUS_W-1:0]    status;
   logic                            req_xfer;
   logic                            advance;

   rwc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rwc_window u_window (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .mode   (in_mode_ff),
      .seq    (in_seq_ff),
      .cfg    (cfg),
      .status (status)
   );

   // move the held request on whenever the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_mode_ff <= req_mode;
         in_seq_ff  <= req_sequence_req;
      end
      if (advance) begin
         out_status_ff <= status;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;

endmodule
